// ===== src/mmn_pkg.sv =====
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types and constants for the min-max normalizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mmn_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned STEP_W   = $clog2(FRAC_W);

  localparam logic [FRAC_W-1:0] FRAC_MAX = {FRAC_W{1'b1}};

  // Sequencer states
  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_READ  = 5'b00010,
    S_START = 5'b00100,
    S_DIV   = 5'b01000,
    S_PUSH  = 5'b10000
  } seq_state_t;

  // Divider request: num / den with num <= den
  typedef struct packed {
    logic                start;
    logic [SAMPLE_W-1:0] num;
    logic [SAMPLE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quotient;
  } div_rsp_t;

endpackage : mmn_pkg

`default_nettype wire

// ===== src/mmn_store.sv =====
// ----------------------------------------------------------------------------
// mmn_store
// Sample buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmn_store #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = 6
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [ADDR_W-1:0]            wr_addr,
  input  wire logic [mmn_pkg::SAMPLE_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]            rd_addr,
  output logic      [mmn_pkg::SAMPLE_W-1:0] rd_data
);
  import mmn_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : mmn_store

`default_nettype wire

// ===== src/mmn_divider.sv =====
// ----------------------------------------------------------------------------
// mmn_divider
// Restoring fraction divider: num / den as Q0.16, one quotient bit a cycle.
// Requires num <= den; num == den saturates to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module mmn_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mmn_pkg::div_req_t req,
  output mmn_pkg::div_rsp_t      rsp
);
  import mmn_pkg::*;

  logic                busy;
  logic                done;
  logic                sat;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] den;
  logic [FRAC_W-1:0]   quo;

  logic [SAMPLE_W:0]   rem_sh;
  logic [SAMPLE_W:0]   rem_diff;
  logic                fits;

  // remainder stays below den, so the shifted value needs one extra bit
  assign rem_sh   = {rem, 1'b0};
  assign rem_diff = rem_sh - {1'b0, den};
  assign fits     = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      den <= req.den;
      quo <= '0;
      sat <= (req.num == req.den);
    end else if (busy) begin
      if (fits) begin
        rem <= rem_diff[SAMPLE_W-1:0];
      end else begin
        rem <= rem_sh[SAMPLE_W-1:0];
      end
      quo <= {quo[FRAC_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = sat ? FRAC_MAX : quo;

endmodule : mmn_divider

`default_nettype wire

// ===== src/min_max_normalizer.sv =====
// ----------------------------------------------------------------------------
// min_max_normalizer
// Buffers a block of signed Q16.16 samples, then emits each as
// (x - min) / (max - min) in unsigned Q0.16.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): sample, last_sample. Samples are taken
// one per cycle while loading; the running min and max are kept on the fly.
// Up to BLOCK_DEPTH samples are stored, later ones are dropped and flag the
// block as overflowed. A sample with last_sample set ends the block.
// Output channel (out_valid / out_stall): one item per stored sample, in
// arrival order, with last_result on the final one.
// After the last sample, the sequencer reads each sample from the buffer and
// runs it through a shared 16-step restoring divider. Each result takes a
// buffer read, a divider load, the 16 steps, a done flag and an output load,
// plus any output stall. The input is stalled for the whole emission phase,
// so a new block loads only after the last result of a block is pushed.
// A stalled result holds in the output register and the sequencer waits.
// The last result of a block may sit in the output register while the next
// block loads. Reset empties the block and clears out_valid; no
// buffer clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_normalizer #(
  parameter int unsigned BLOCK_DEPTH = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [mmn_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                         last_sample,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [mmn_pkg::FRAC_W-1:0]   scaled_value,
  output logic                              degenerate,
  output logic                              overflowed,
  output logic                              last_result
);
  import mmn_pkg::*;

  localparam int unsigned ADDR_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int unsigned CNT_W  = ADDR_W + 1;

  seq_state_t          state;
  seq_state_t          state_next;
  logic [CNT_W-1:0]    count;
  logic [ADDR_W-1:0]   idx;
  logic [SAMPLE_W-1:0] run_min;
  logic [SAMPLE_W-1:0] run_max;
  logic                drop;

  logic                in_fire;
  logic                room;
  logic                out_free;
  logic                push_fire;
  logic                idx_last;
  logic                degen;
  logic [SAMPLE_W-1:0] rd_data;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  assign in_stall  = (state != S_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign room      = (count < CNT_W'(BLOCK_DEPTH));
  assign out_free  = !out_valid || !out_stall;
  assign push_fire = (state == S_PUSH) && out_free;
  assign idx_last  = ({1'b0, idx} + 1'b1 == count);
  assign degen     = (run_min == run_max);

  // ---------------- sample buffer ----------------
  mmn_store #(
    .DEPTH  (BLOCK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_fire && room),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (sample),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  // ---------------- shared divider ----------------
  assign div_req.start = (state == S_START);
  assign div_req.num   = rd_data - run_min;
  assign div_req.den   = run_max - run_min;

  mmn_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_fire && last_sample) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          state_next = idx_last ? S_LOAD : S_READ;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      count   <= '0;
      idx     <= '0;
      run_min <= '0;
      run_max <= '0;
      drop    <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        idx <= '0;
        if (room) begin
          count <= count + 1'b1;
          if (count == '0) begin
            run_min <= sample;
            run_max <= sample;
          end else begin
            if ($signed(sample) > $signed(run_max)) begin
              run_max <= sample;
            end
            if ($signed(sample) < $signed(run_min)) begin
              run_min <= sample;
            end
          end
        end else begin
          drop <= 1'b1;
        end
      end else if (push_fire) begin
        if (idx_last) begin
          count   <= '0;
          run_min <= '0;
          run_max <= '0;
          drop    <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      scaled_value <= degen ? '0 : div_rsp.quotient;
      degenerate   <= degen;
      overflowed   <= drop;
      last_result  <= idx_last;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(BLOCK_DEPTH))
    else $error("stored count exceeds buffer depth");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> ($signed(run_min) <= $signed(run_max)))
    else $error("running min above running max");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside divide state");

  a_valid_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_PUSH))
    else $error("result presented without a push");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (count != '0))
    else $error("emission started with an empty block");
`endif

endmodule : min_max_normalizer

`default_nettype wire
